// File: rtl/core/gpio_fl_pkg.sv
// shared types and constants for the gpio function select and level register block
// no dependencies

package gpio_fl_pkg;

    localparam int PIN_COUNT_DEF = 54;
    localparam int PIN_SLOTS     = 64;
    localparam int WORD_BITS     = 32;
    localparam int SEL_W         = 3;
    localparam int SELS_PER_WORD = 10;
    localparam int FSEL_WORDS    = 6;
    localparam int FSEL_BITS     = SELS_PER_WORD * SEL_W;
    localparam int FSEL_IDX_W    = $clog2(FSEL_WORDS);
    localparam int OFFSET_W      = 8;
    localparam int WIDX_W        = OFFSET_W - 2;

    // word index (byte offset / 4) of each register in the map
    localparam logic [WIDX_W-1:0] W_FSEL0  = 6'h00;
    localparam logic [WIDX_W-1:0] W_FSEL1  = 6'h01;
    localparam logic [WIDX_W-1:0] W_FSEL2  = 6'h02;
    localparam logic [WIDX_W-1:0] W_FSEL3  = 6'h03;
    localparam logic [WIDX_W-1:0] W_FSEL4  = 6'h04;
    localparam logic [WIDX_W-1:0] W_FSEL5  = 6'h05;
    localparam logic [WIDX_W-1:0] W_SET0   = 6'h07;
    localparam logic [WIDX_W-1:0] W_SET1   = 6'h08;
    localparam logic [WIDX_W-1:0] W_CLR0   = 6'h0A;
    localparam logic [WIDX_W-1:0] W_CLR1   = 6'h0B;
    localparam logic [WIDX_W-1:0] W_LEV0   = 6'h0D;
    localparam logic [WIDX_W-1:0] W_LEV1   = 6'h0E;
    localparam logic [WIDX_W-1:0] W_EDS0   = 6'h10;
    localparam logic [WIDX_W-1:0] W_EDS1   = 6'h11;
    localparam logic [WIDX_W-1:0] W_REN0   = 6'h13;
    localparam logic [WIDX_W-1:0] W_REN1   = 6'h14;
    localparam logic [WIDX_W-1:0] W_FEN0   = 6'h16;
    localparam logic [WIDX_W-1:0] W_FEN1   = 6'h17;
    localparam logic [WIDX_W-1:0] W_HEN0   = 6'h19;
    localparam logic [WIDX_W-1:0] W_HEN1   = 6'h1A;
    localparam logic [WIDX_W-1:0] W_LEN0   = 6'h1C;
    localparam logic [WIDX_W-1:0] W_LEN1   = 6'h1D;
    localparam logic [WIDX_W-1:0] W_AREN0  = 6'h1F;
    localparam logic [WIDX_W-1:0] W_AREN1  = 6'h20;
    localparam logic [WIDX_W-1:0] W_AFEN0  = 6'h22;
    localparam logic [WIDX_W-1:0] W_AFEN1  = 6'h23;
    localparam logic [WIDX_W-1:0] W_PUD    = 6'h25;
    localparam logic [WIDX_W-1:0] W_UDCLK0 = 6'h26;
    localparam logic [WIDX_W-1:0] W_UDCLK1 = 6'h27;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNIMPL  = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_FSEL = 3'd1,
        OP_SET  = 3'd2,
        OP_CLR  = 3'd3,
        OP_LEV  = 3'd4
    } op_t;

    // decoded access handed from the input stage to the pin registers
    typedef struct packed {
        op_t                   op;
        status_t               status;
        logic                  is_write;
        logic                  hi_half;
        logic [FSEL_IDX_W-1:0] fsel_word;
        logic [WORD_BITS-1:0]  data;
    } acc_t;

endpackage

// File: rtl/core/gpio_fl_decode.sv
// input register and address decode of one register access
// depends on gpio_fl_pkg

module gpio_fl_decode
    import gpio_fl_pkg::*;
(
    input  logic                 clk,
    input  logic                 load,
    input  logic                 kind,
    input  logic [OFFSET_W-1:0]  reg_offset,
    input  logic [WORD_BITS-1:0] write_data,
    output acc_t                 acc
);

    logic                 kind_reg;
    logic [OFFSET_W-1:0]  offset_reg;
    logic [WORD_BITS-1:0] data_reg;
    logic [WIDX_W-1:0]    widx;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= kind;
            offset_reg <= reg_offset;
            data_reg   <= write_data;
        end
    end

    assign widx = offset_reg[OFFSET_W-1:2];

    always_comb
    begin
        acc           = '0;
        acc.op        = OP_NONE;
        acc.status    = ST_INVALID;
        acc.is_write  = kind_reg;
        acc.hi_half   = (widx == W_SET1) || (widx == W_CLR1) || (widx == W_LEV1);
        acc.fsel_word = widx[FSEL_IDX_W-1:0];
        acc.data      = data_reg;
        unique case (widx) inside
            W_FSEL0, W_FSEL1, W_FSEL2, W_FSEL3, W_FSEL4, W_FSEL5:
            begin
                acc.op     = OP_FSEL;
                acc.status = ST_OK;
            end
            W_SET0, W_SET1:
            begin
                acc.op     = OP_SET;
                acc.status = ST_OK;
            end
            W_CLR0, W_CLR1:
            begin
                acc.op     = OP_CLR;
                acc.status = ST_OK;
            end
            W_LEV0, W_LEV1:
            begin
                // level registers are read only
                if (kind_reg)
                begin
                    acc.op     = OP_NONE;
                    acc.status = ST_UNIMPL;
                end
                else
                begin
                    acc.op     = OP_LEV;
                    acc.status = ST_OK;
                end
            end
            W_EDS0, W_EDS1, W_REN0, W_REN1, W_FEN0, W_FEN1, W_HEN0, W_HEN1,
            W_LEN0, W_LEN1, W_AREN0, W_AREN1, W_AFEN0, W_AFEN1, W_PUD,
            W_UDCLK0, W_UDCLK1:
            begin
                acc.op     = OP_NONE;
                acc.status = ST_UNIMPL;
            end
            default:
            begin
                acc.op     = OP_NONE;
                acc.status = ST_INVALID;
            end
        endcase
    end

endmodule

// File: rtl/core/gpio_fl_pins.sv
// per-pin function select and output level registers, update and read mux
// depends on gpio_fl_pkg

module gpio_fl_pins
    import gpio_fl_pkg::*;
#(
    parameter int PIN_COUNT = PIN_COUNT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 apply,
    input  acc_t                 acc,
    output logic [WORD_BITS-1:0] read_data
);

    localparam int FSEL_PINS = FSEL_WORDS * SELS_PER_WORD;
    localparam int FUNC_PINS = (PIN_COUNT < FSEL_PINS) ? PIN_COUNT : FSEL_PINS;

    logic [FSEL_PINS*SEL_W-1:0] fsel_flat;
    logic [FSEL_BITS-1:0]       fsel_words [FSEL_WORDS];
    logic [PIN_SLOTS-1:0]       lev_full;
    logic [WORD_BITS-1:0]       lev_word;
    logic [WORD_BITS-1:0]       rd_word;
    logic                       fsel_wr;
    logic                       set_wr;
    logic                       clr_wr;

    assign fsel_wr = apply && acc.is_write && (acc.op == OP_FSEL);
    assign set_wr  = apply && acc.is_write && (acc.op == OP_SET);
    assign clr_wr  = apply && acc.is_write && (acc.op == OP_CLR);

    for (genvar p = 0; p < FSEL_PINS; p++)
    begin : g_func
        if (p < FUNC_PINS)
        begin : g_used
            localparam int WORD = p / SELS_PER_WORD;
            localparam int LSB  = (p % SELS_PER_WORD) * SEL_W;
            logic [SEL_W-1:0] func_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    func_reg <= '0;
                else if (fsel_wr && (acc.fsel_word == FSEL_IDX_W'(WORD)))
                    func_reg <= acc.data[LSB +: SEL_W];
            end

            assign fsel_flat[p*SEL_W +: SEL_W] = func_reg;
        end
        else
        begin : g_absent
            assign fsel_flat[p*SEL_W +: SEL_W] = '0;
        end
    end

    for (genvar w = 0; w < FSEL_WORDS; w++)
    begin : g_fword
        assign fsel_words[w] = fsel_flat[w*FSEL_BITS +: FSEL_BITS];
    end

    for (genvar p = 0; p < PIN_SLOTS; p++)
    begin : g_level
        if (p < PIN_COUNT)
        begin : g_used
            localparam logic HALF = (p >= WORD_BITS);
            localparam int   BIT  = p % WORD_BITS;
            logic            lvl_reg;
            logic            hit;

            assign hit = (acc.hi_half == HALF) && acc.data[BIT];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    lvl_reg <= 1'b0;
                else if (set_wr && hit)
                    lvl_reg <= 1'b1;
                else if (clr_wr && hit)
                    lvl_reg <= 1'b0;
            end

            assign lev_full[p] = lvl_reg;
        end
        else
        begin : g_absent
            assign lev_full[p] = 1'b0;
        end
    end

    assign lev_word = acc.hi_half ? lev_full[PIN_SLOTS-1:WORD_BITS]
                                  : lev_full[WORD_BITS-1:0];

    always_comb
    begin
        case (acc.op) inside
            OP_FSEL:        rd_word = WORD_BITS'(fsel_words[acc.fsel_word]);
            OP_SET, OP_LEV: rd_word = lev_word;
            // clear register reads back the inverted levels, absent pins as 1
            OP_CLR:         rd_word = ~lev_word;
            default:        rd_word = '0;
        endcase
    end

    assign read_data = (acc.is_write || (acc.status != ST_OK)) ? '0 : rd_word;

endmodule

// File: rtl/core/gpio_function_and_level_regs.sv
// top level of the gpio function select and level register block
// depends on gpio_fl_pkg, gpio_fl_decode and gpio_fl_pins

// One register access per transfer on the input stream, one result per access on the
// output stream. An access is taken every cycle when the output side keeps up; it
// is held in the input register and decoded there, its result is loaded into the
// result register once the output side can take it and waits there until it is taken.
// Pin state is held in flip-flops cleared by reset, so the block is ready right out of
// reset. Writes take effect before the next access is decoded, so a read right after
// a write sees the written value.

module gpio_function_and_level_regs
    import gpio_fl_pkg::*;
#(
    parameter int PIN_COUNT = PIN_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // reg_offset[7:0], write_data[39:8]
    input  logic        s_tuser,   // kind (0 read, 1 write)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_data[31:0]
    output logic [1:0]  m_tuser    // status[1:0]
);

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [WORD_BITS-1:0] out_data_reg;
    logic [1:0]           out_status_reg;
    logic                 advance;
    logic                 in_xfer;
    logic                 apply;
    acc_t                 acc;
    logic [WORD_BITS-1:0] read_data;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || advance;
    assign in_xfer  = s_tvalid && s_tready;
    assign apply    = s1_valid_reg && advance;

    gpio_fl_decode u_decode (
        .clk        (clk),
        .load       (in_xfer),
        .kind       (s_tuser),
        .reg_offset (s_tdata[OFFSET_W-1:0]),
        .write_data (s_tdata[OFFSET_W +: WORD_BITS]),
        .acc        (acc)
    );

    gpio_fl_pins #(
        .PIN_COUNT (PIN_COUNT)
    ) u_pins (
        .clk       (clk),
        .rst_n     (rst_n),
        .apply     (apply),
        .acc       (acc),
        .read_data (read_data)
    );

    always_comb
    begin
        if (in_xfer)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        out_valid_next = advance ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (apply)
        begin
            out_data_reg   <= read_data;
            out_status_reg <= acc.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

endmodule

// File: bench/gpio_access_checker.sv
`timescale 1ns / 100ps
// checker for the gpio function select and level register block: watches both streams,
// keeps its own copy of the pin state and compares every result with the predicted one
// depends on gpio_fl_pkg

module gpio_access_checker
    import gpio_fl_pkg::*;
#(
    parameter int PIN_COUNT = PIN_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // reg_offset[7:0], write_data[39:8]
    input  logic        s_tuser,   // kind (0 read, 1 write)
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // read_data[31:0]
    input  logic [1:0]  m_tuser,   // status[1:0]
    output int          fail_count,
    output int          outstanding
);

    typedef struct packed {
        logic [WORD_BITS-1:0] read_data;
        status_t              status;
    } reply_t;

    logic [SEL_W-1:0] pin_sel [PIN_SLOTS];
    logic             pin_lvl [PIN_SLOTS];
    reply_t           awaited_replies [$];
    reply_t           want;

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    // applies one access to the pin copy and returns what the block should answer
    function automatic reply_t predict_access(input logic wr, input logic [7:0] off,
                                              input logic [31:0] data);
        reply_t           r;
        logic [WIDX_W-1:0] widx;
        int               base;
        int               first;
        int               p;
        r.read_data = '0;
        r.status    = ST_OK;
        widx        = off[7:2];
        case (widx) inside
            W_FSEL0, W_FSEL1, W_FSEL2, W_FSEL3, W_FSEL4, W_FSEL5:
            begin
                base = int'(widx) * SELS_PER_WORD;
                for (int i = 0; i < SELS_PER_WORD; i++)
                begin
                    p = base + i;
                    if (p < PIN_COUNT)
                    begin
                        if (wr)
                            pin_sel[p] = data[SEL_W*i +: SEL_W];
                        else
                            r.read_data[SEL_W*i +: SEL_W] = pin_sel[p];
                    end
                end
            end
            W_SET0, W_SET1, W_CLR0, W_CLR1, W_LEV0, W_LEV1:
            begin
                first = (widx == W_SET1 || widx == W_CLR1 || widx == W_LEV1) ? WORD_BITS : 0;
                // level registers are read only
                if (wr && (widx == W_LEV0 || widx == W_LEV1))
                    r.status = ST_UNIMPL;
                else
                begin
                    for (int i = 0; i < WORD_BITS; i++)
                    begin
                        p = first + i;
                        if (p < PIN_COUNT)
                        begin
                            if (!wr)
                                r.read_data[i] = pin_lvl[p];
                            else if (data[i])
                                pin_lvl[p] = (widx == W_SET0 || widx == W_SET1);
                        end
                    end
                end
                // clr reads invert the whole word, missing pins included
                if (!wr && (widx == W_CLR0 || widx == W_CLR1))
                    r.read_data = ~r.read_data;
            end
            W_EDS0, W_EDS1, W_REN0, W_REN1, W_FEN0, W_FEN1, W_HEN0, W_HEN1,
            W_LEN0, W_LEN1, W_AREN0, W_AREN1, W_AFEN0, W_AFEN1, W_PUD,
            W_UDCLK0, W_UDCLK1:
                r.status = ST_UNIMPL;
            default:
                r.status = ST_INVALID;
        endcase
        if (wr || r.status != ST_OK)
            r.read_data = '0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PIN_SLOTS; p++)
            begin
                pin_sel[p] = '0;
                pin_lvl[p] = 1'b0;
            end
            awaited_replies.delete();
            outstanding = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (awaited_replies.size() == 0)
                    report_mismatch("result transfer with no access outstanding");
                else
                begin
                    want = awaited_replies.pop_front();
                    if (m_tdata !== want.read_data)
                        report_mismatch($sformatf("read_data %h, predicted %h",
                                                  m_tdata, want.read_data));
                    if (m_tuser !== want.status)
                        report_mismatch($sformatf("status %0d, predicted %0d",
                                                  m_tuser, want.status));
                end
            end
            if (s_tvalid && s_tready)
                awaited_replies.push_back(predict_access(s_tuser, s_tdata[7:0],
                                                         s_tdata[39:8]));
            outstanding = awaited_replies.size();
        end
    end

endmodule

// File: bench/gpio_function_and_level_regs_tb.sv
`timescale 1ns / 100ps
// testbench top for gpio_function_and_level_regs: drives register accesses with bursts
// and gaps, stalls the result side, and reports the verdict from gpio_access_checker
// depends on gpio_fl_pkg, gpio_access_checker and the block itself

module gpio_function_and_level_regs_tb
    import gpio_fl_pkg::*;
();

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;
    localparam int   RANDOM_ACCESSES = 750;
    localparam int   IDLE_LIMIT      = 2000;
    localparam int   KNOWN_WORDS     = 29;  // first 12 implemented, the rest not
    localparam int   IMPL_WORDS      = 12;

    typedef enum int {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE,
        RDY_TWO_OF_THREE
    } ready_mode_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // reg_offset[7:0], write_data[39:8]
    logic        s_tuser;   // kind (0 read, 1 write)
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // read_data[31:0]
    logic [1:0]  m_tuser;   // status[1:0]

    int          fail_count;
    int          outstanding;
    int          burst_left;
    int          idle_cycles;
    ready_mode_t ready_mode;
    int          ready_phase;

    always #10 clk = ~clk;

    gpio_function_and_level_regs i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    gpio_access_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    function automatic logic [7:0] at_word(input logic [WIDX_W-1:0] widx);
        return {widx, 2'b00};
    endfunction

    function automatic logic [WIDX_W-1:0] known_word(input int n);
        case (n)
            0:       return W_FSEL0;
            1:       return W_FSEL1;
            2:       return W_FSEL2;
            3:       return W_FSEL3;
            4:       return W_FSEL4;
            5:       return W_FSEL5;
            6:       return W_SET0;
            7:       return W_SET1;
            8:       return W_CLR0;
            9:       return W_CLR1;
            10:      return W_LEV0;
            11:      return W_LEV1;
            12:      return W_EDS0;
            13:      return W_EDS1;
            14:      return W_REN0;
            15:      return W_REN1;
            16:      return W_FEN0;
            17:      return W_FEN1;
            18:      return W_HEN0;
            19:      return W_HEN1;
            20:      return W_LEN0;
            21:      return W_LEN1;
            22:      return W_AREN0;
            23:      return W_AREN1;
            24:      return W_AFEN0;
            25:      return W_AFEN1;
            26:      return W_PUD;
            27:      return W_UDCLK0;
            default: return W_UDCLK1;
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_access(input logic kind, input logic [7:0] off,
                               input logic [31:0] data);
        if (burst_left == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {data, off};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        burst_left = 0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic random_access();
        int                sel;
        logic [7:0]        off;
        logic [31:0]       data;
        logic [WIDX_W-1:0] widx;
        sel = $urandom_range(0, 99);
        if (sel < 72)
            widx = known_word($urandom_range(0, IMPL_WORDS - 1));
        else if (sel < 87)
            widx = known_word($urandom_range(IMPL_WORDS, KNOWN_WORDS - 1));
        else
            widx = WIDX_W'($urandom_range(0, 63));
        off = {widx, 2'($urandom_range(0, 3))};
        // sparse masks keep the pin levels mixed instead of all set or all clear
        data = ($urandom_range(0, 1) == 0) ? $urandom : ($urandom & $urandom & $urandom);
        send_access(1'($urandom_range(0, 1)), off, data);
    endtask

    // result side stalls on its own changing pattern
    initial
    begin
        m_tready    = 1'b0;
        ready_phase = 0;
        forever
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            repeat ($urandom_range(16, 96))
            begin
                @(negedge clk);
                case (ready_mode)
                    RDY_ALWAYS: m_tready = 1'b1;
                    RDY_COIN:   m_tready = 1'($urandom_range(0, 1));
                    RDY_SPARSE: m_tready = ($urandom_range(0, 3) == 0);
                    default:    m_tready = (ready_phase % 3 != 0);
                endcase
                ready_phase++;
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = KIND_READ;
        burst_left = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset values, full-width selects, pins past the end, set and clr
        // halves, read-only levels, unimplemented and out-of-map offsets
        send_access(KIND_READ,  at_word(W_FSEL0), 32'h0);
        send_access(KIND_WRITE, at_word(W_FSEL0), 32'hFFFF_FFFF);
        send_access(KIND_READ,  at_word(W_FSEL0), 32'h0);
        send_access(KIND_WRITE, at_word(W_FSEL5), 32'hFFFF_FFFF);
        send_access(KIND_READ,  at_word(W_FSEL5), 32'h0);
        send_access(KIND_WRITE, at_word(W_FSEL3), 32'h1234_5678);
        send_access(KIND_READ,  at_word(W_FSEL3), 32'hFFFF_FFFF);
        send_access(KIND_WRITE, at_word(W_SET0),  32'hFFFF_FFFF);
        send_access(KIND_WRITE, at_word(W_SET1),  32'hFFFF_FFFF);
        send_access(KIND_READ,  at_word(W_LEV0),  32'h0);
        send_access(KIND_READ,  at_word(W_LEV1),  32'h0);
        send_access(KIND_READ,  at_word(W_CLR1),  32'h0);
        send_access(KIND_READ,  at_word(W_CLR0),  32'h0);
        send_access(KIND_WRITE, at_word(W_CLR0),  32'h0000_FFFF);
        send_access(KIND_READ,  at_word(W_SET0) | 8'h3, 32'h0);
        send_access(KIND_WRITE, at_word(W_CLR1),  32'hFFFF_FFFF);
        send_access(KIND_READ,  at_word(W_SET1),  32'h0);
        send_access(KIND_WRITE, at_word(W_LEV0),  32'hFFFF_FFFF);
        send_access(KIND_READ,  at_word(W_LEV0),  32'h0);
        send_access(KIND_READ,  at_word(W_EDS0),  32'h0);
        send_access(KIND_WRITE, at_word(W_PUD),   32'hFFFF_FFFF);
        send_access(KIND_READ,  at_word(W_UDCLK1), 32'h0);
        send_access(KIND_READ,  8'hA0,            32'h0);
        send_access(KIND_WRITE, 8'h18,            32'hFFFF_FFFF);
        send_access(KIND_READ,  8'hFF,            32'h0);
        wait_drained();

        for (int n = 0; n < RANDOM_ACCESSES; n++)
        begin
            if (n == RANDOM_ACCESSES / 2)
                wait_drained();
            random_access();
        end
        wait_drained();
        repeat (8) @(negedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
